// ----- src/arope_pkg.sv -----
// shared types and constants for the axial rotary embedding block
package arope_pkg;

  // sin/cos operand width and fixed point shift (Q1.14)
  localparam int TRIG_W     = 16;
  localparam int FRAC_SHIFT = 14;

  // configuration register widths
  localparam int SEQ_LEN_W  = 13;
  localparam int ROT_LEN_W  = 13;
  localparam int QLEN_W     = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // configuration register reset values
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RST = SEQ_LEN_W'(1);
  localparam logic [ROT_LEN_W-1:0] ROT_LEN_RST = '0;
  localparam logic [QLEN_W-1:0]    QLEN_RST    = QLEN_W'(1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEQ_LEN     = 2'd0,
    CFG_ROT_LEN     = 2'd1,
    CFG_QUARTER_LEN = 2'd2
  } cfg_idx_t;

  // per-beat control flags carried alongside the data
  typedef struct packed {
    logic seq_end;
    logic token_end;
    logic rotated;
  } arope_flags_t;

endpackage

// ----- src/arope_mac.sv -----
// one rotate-half output: a*ca -/+ b*sb, rounded, shifted and saturated
module arope_mac import arope_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [TRIG_W-1:0]     ca,
  input  logic signed [DATA_WIDTH-1:0] b,
  input  logic signed [TRIG_W-1:0]     sb,
  input  logic                         subtract,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int PW = DATA_WIDTH + TRIG_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (DATA_WIDTH - 1)));
  localparam logic signed [SW-1:0] RND    = SW'(64'sd1 <<< (FRAC_SHIFT - 1));

  logic signed [PW-1:0] prod_a;
  logic signed [PW-1:0] prod_b;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] scaled;

  // two products, exact sum
  assign prod_a = a * ca;
  assign prod_b = b * sb;
  assign sum    = subtract ? (SW'(prod_a) - SW'(prod_b)) : (SW'(prod_a) + SW'(prod_b));

  // round half up, floor shift
  assign scaled = (sum + RND) >>> FRAC_SHIFT;

  // saturate to the data width
  always_comb begin
    if (scaled > SAT_HI) begin
      result = SAT_HI[DATA_WIDTH-1:0];
    end else if (scaled < SAT_LO) begin
      result = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      result = scaled[DATA_WIDTH-1:0];
    end
  end

endmodule

// ----- src/axial_rotary_embedding_2d.sv -----
// axial 2d rotary embedding: top level with counters, config and two-register pipeline
// an accepted input beat is held in the input register, then in the result register that drives the output
// throughput: one beat per cycle, set by the single input register and result register
// the input side stalls only when both registers hold beats and out_tready is low
// reset (rst_n low, synchronous) empties the pipeline, clears the lane and token
// counters and sets seq_len = 1, rot_len = 0, quarter_len = 1
module axial_rotary_embedding_2d import arope_pkg::*; #(
  parameter int MAX_LANES  = 64,
  parameter int MAX_TOKENS = 4096,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // low to high: x_front, x_back, y_front, y_back (DATA_WIDTH each),
  // xf_cos, xb_cos, yf_cos, yb_cos,
  // xf_sin, xb_sin, yf_sin, yb_sin (16 each), zero pad to bytes
  input  logic [((4*DATA_WIDTH+4*TRIG_W*2+7)/8)*8-1:0] in_tdata,
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // low to high: rot_x_front, rot_x_back, rot_y_front, rot_y_back, zero pad to bytes
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  // token_end
  output logic                                    out_tlast,
  // low to high: was_rotated, sequence_end
  output logic [1:0]                              out_tuser,
  // configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]                   cfg_data
);

  localparam int DW     = DATA_WIDTH;
  localparam int LIDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int TIDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int LNW    = ($clog2(MAX_LANES + 1) > QLEN_W) ? $clog2(MAX_LANES + 1) : QLEN_W;
  localparam int TKW0   = ($clog2(MAX_TOKENS + 1) > SEQ_LEN_W) ? $clog2(MAX_TOKENS + 1)
                                                                : SEQ_LEN_W;
  localparam int TKW    = (TKW0 > ROT_LEN_W) ? TKW0 : ROT_LEN_W;

  // configuration registers
  logic [SEQ_LEN_W-1:0] seq_len_r;
  logic [ROT_LEN_W-1:0] rot_len_r;
  logic [QLEN_W-1:0]    quarter_len_r;

  // position counters
  logic [LIDX_W-1:0] lane_idx_r, lane_idx_nxt;
  logic [TIDX_W-1:0] tok_idx_r, tok_idx_nxt;

  // derived lengths
  logic [LNW-1:0] lanes_eff, lanes_m1;
  logic [TKW-1:0] toks_eff, toks_m1, prefix;
  arope_flags_t   flags_nxt;
  logic           last_lane, last_token;

  // pipeline registers
  logic                         s1_valid_r;
  arope_flags_t                 s1_flags_r;
  logic signed [DW-1:0]         s1_d_r [4];
  logic signed [TRIG_W-1:0]     s1_c_r [4];
  logic signed [TRIG_W-1:0]     s1_s_r [4];
  logic                         out_valid_r;
  arope_flags_t                 out_flags_r;
  logic signed [DW-1:0]         out_d_r [4];
  logic signed [DW-1:0]         rot_res [4];
  logic                         s1_adv, in_acc;

  assign cfg_ready = 1'b1;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r     <= SEQ_LEN_RST;
      rot_len_r     <= ROT_LEN_RST;
      quarter_len_r <= QLEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEQ_LEN:     seq_len_r     <= cfg_data[SEQ_LEN_W-1:0];
        CFG_ROT_LEN:     rot_len_r     <= cfg_data[ROT_LEN_W-1:0];
        CFG_QUARTER_LEN: quarter_len_r <= cfg_data[QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths and locate the rotated tail
  always_comb begin
    if (quarter_len_r == '0) begin
      lanes_eff = LNW'(1);
    end else if (LNW'(quarter_len_r) > LNW'(MAX_LANES)) begin
      lanes_eff = LNW'(MAX_LANES);
    end else begin
      lanes_eff = LNW'(quarter_len_r);
    end
    if (seq_len_r == '0) begin
      toks_eff = TKW'(1);
    end else if (TKW'(seq_len_r) > TKW'(MAX_TOKENS)) begin
      toks_eff = TKW'(MAX_TOKENS);
    end else begin
      toks_eff = TKW'(seq_len_r);
    end
    lanes_m1 = lanes_eff - LNW'(1);
    toks_m1  = toks_eff - TKW'(1);
    prefix   = (TKW'(rot_len_r) >= toks_eff) ? '0 : (toks_eff - TKW'(rot_len_r));
    last_lane  = LNW'(lane_idx_r) >= lanes_m1;
    last_token = TKW'(tok_idx_r) >= toks_m1;
    flags_nxt.rotated   = TKW'(tok_idx_r) >= prefix;
    flags_nxt.token_end = last_lane;
    flags_nxt.seq_end   = last_lane && last_token;
  end

  // counter advance
  always_comb begin
    lane_idx_nxt = lane_idx_r;
    tok_idx_nxt  = tok_idx_r;
    if (last_lane) begin
      lane_idx_nxt = '0;
      tok_idx_nxt  = last_token ? '0 : tok_idx_r + TIDX_W'(1);
    end else begin
      lane_idx_nxt = lane_idx_r + LIDX_W'(1);
    end
  end

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_idx_r  <= '0;
      tok_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        lane_idx_r <= lane_idx_nxt;
        tok_idx_r  <= tok_idx_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= flags_nxt;
      for (int i = 0; i < 4; i++) begin
        s1_d_r[i] <= in_tdata[i*DW +: DW];
        s1_c_r[i] <= in_tdata[4*DW + i*TRIG_W +: TRIG_W];
        s1_s_r[i] <= in_tdata[4*DW + 4*TRIG_W + i*TRIG_W +: TRIG_W];
      end
    end
  end

  // rotate-half within the x pair and within the y pair
  arope_mac #(.DATA_WIDTH(DW)) u_mac_xf (
    .a(s1_d_r[0]), .ca(s1_c_r[0]), .b(s1_d_r[1]), .sb(s1_s_r[0]),
    .subtract(1'b1), .result(rot_res[0])
  );
  arope_mac #(.DATA_WIDTH(DW)) u_mac_xb (
    .a(s1_d_r[1]), .ca(s1_c_r[1]), .b(s1_d_r[0]), .sb(s1_s_r[1]),
    .subtract(1'b0), .result(rot_res[1])
  );
  arope_mac #(.DATA_WIDTH(DW)) u_mac_yf (
    .a(s1_d_r[2]), .ca(s1_c_r[2]), .b(s1_d_r[3]), .sb(s1_s_r[2]),
    .subtract(1'b1), .result(rot_res[2])
  );
  arope_mac #(.DATA_WIDTH(DW)) u_mac_yb (
    .a(s1_d_r[3]), .ca(s1_c_r[3]), .b(s1_d_r[2]), .sb(s1_s_r[3]),
    .subtract(1'b0), .result(rot_res[3])
  );

  // result register: prefix tokens pass through
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_flags_r <= s1_flags_r;
      for (int i = 0; i < 4; i++) begin
        out_d_r[i] <= s1_flags_r.rotated ? rot_res[i] : s1_d_r[i];
      end
    end
  end

  // output packing
  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 4; i++) begin
      out_tdata[i*DW +: DW] = out_d_r[i];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tlast    = out_flags_r.token_end;
  assign out_tuser[0] = out_flags_r.rotated;
  assign out_tuser[1] = out_flags_r.seq_end;

endmodule

// ----- src/arope_checker.sv -----
// port-level checks for the axial rotary embedding block, bound to the top level
module arope_checker import arope_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_tvalid,
  input logic                                    in_tready,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  input logic                                    out_tlast,
  input logic [1:0]                              out_tuser
);

  // a sequence end is always also a token end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tlast))
    else $error("sequence end without token end");

  // an empty result register never holds back the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

  // a stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)
                                     && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind axial_rotary_embedding_2d arope_checker #(.DATA_WIDTH(DATA_WIDTH)) u_arope_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tlast(out_tlast),
  .out_tuser(out_tuser)
);
